// File: design/ols_pkg.sv
// Shared types and codes for the ordered list store.
package ols_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int IDX_W          = 10;
	localparam int CNT_W          = 11;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_SEARCH = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_POS = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_MISSING = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] len;
	} cell_ctl_t;

endpackage

// File: design/ols_cell.sv
// One storage cell of the list: holds an entry, shifts to or from its neighbours, compares.
module ols_cell #(
	parameter int INDEX      = 0,
	parameter int DATA_WIDTH = ols_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  ols_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match
);
	import ols_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (IDX == ctl.pos) begin
				data_q <= word;
			end else if (IDX > ctl.pos) begin
				data_q <= left;
			end
		end else if (ctl.del && IDX >= ctl.pos) begin
			data_q <= right;
		end
	end

	assign data  = data_q;
	assign match = (IDX < ctl.len) && (data_q == word);

endmodule

// File: design/ordered_list_store_core.sv
// Top level of the ordered list store: command decode, count, cell row and result register.
// Each item passes execute, then finish (held on output stall), into the result register.
// A new item is taken only when idle; the cell row executes, then the first-match encode.
// Search, insert and delete act on all cells of the row in the same cycle.
// Reset (arst_n low) clears the entry count, control state and output valid; entries are
// left undefined and are never read below the count before being written.
module ordered_list_store_core #(
	parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ols_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic signed [31:0] value,
	input  logic signed [15:0] position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  found_index,
	output logic [10:0] entry_count
);
	import ols_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t                state_q;
	op_t                   op_s1;
	logic [DATA_WIDTH-1:0] word_s1;
	logic [15:0]           pos_s1;
	logic [LW-1:0]         len_q;
	status_t               st_s2;
	logic                  srch_s2;
	logic [CAPACITY-1:0]   match_s2;

	logic                  out_valid_q;
	status_t               status_q;
	logic [IDX_W-1:0]      found_q;
	logic [CNT_W-1:0]      count_q;

	logic [63:0]           value_x;
	logic [CNT_W-1:0]      len_x;
	logic [15:0]           len_16;
	status_t               st_d;
	logic                  do_ins;
	logic                  do_del;
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] data_w [CAPACITY];
	logic [CAPACITY-1:0]   match_w;
	logic [IDX_W-1:0]      found_d;
	status_t               fin_st;
	logic                  out_free;
	logic                  in_fire;

	assign value_x  = {{32{value[31]}}, value};
	assign len_x    = CNT_W'(len_q);
	assign len_16   = 16'(len_q);
	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st_d   = ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		unique case (op_s1)
			OP_APPEND: begin
				if (len_x == CAP) begin
					st_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_s1[15] || pos_s1 > len_16) begin
					st_d = ST_BAD_POS;
				end else if (len_x == CAP) begin
					st_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_SEARCH: begin
				st_d = ST_MISSING;
			end
			OP_DELETE: begin
				if (len_q == '0) begin
					st_d = ST_EMPTY;
				end else if (pos_s1[15] || pos_s1 >= len_16) begin
					st_d = ST_BAD_POS;
				end else begin
					do_del = 1'b1;
				end
			end
			default: st_d = ST_OK;
		endcase
	end

	always_comb begin
		ctl.ins = (state_q == S_EXEC) && do_ins;
		ctl.del = (state_q == S_EXEC) && do_del;
		ctl.pos = (op_s1 == OP_APPEND) ? len_x : pos_s1[CNT_W-1:0];
		ctl.len = len_x;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ols_cell #(
			.INDEX      (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.word  (word_s1),
			.left  ((i == 0) ? word_s1 : data_w[(i == 0) ? 0 : i - 1]),
			.right (data_w[(i == CAPACITY - 1) ? i : i + 1]),
			.data  (data_w[i]),
			.match (match_w[i])
		);
	end

	always_comb begin
		found_d = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match_s2[i]) begin
				found_d = IDX_W'(i);
			end
		end
	end

	always_comb begin
		fin_st = st_s2;
		if (srch_s2 && (match_s2 != '0)) begin
			fin_st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op_t'(opcode);
			word_s1 <= value_x[DATA_WIDTH-1:0];
			pos_s1  <= position;
		end
		if (state_q == S_EXEC) begin
			st_s2    <= st_d;
			srch_s2  <= (op_s1 == OP_SEARCH);
			match_s2 <= match_w;
		end
		if (state_q == S_FIN && out_free) begin
			status_q <= fin_st;
			found_q  <= (srch_s2 && (match_s2 != '0)) ? found_d : '0;
			count_q  <= len_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (do_ins) begin
						len_q <= len_q + LW'(1);
					end else if (do_del) begin
						len_q <= len_q - LW'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign entry_count = count_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_x <= CAP)
		else $error("entry count above capacity");

	a_len_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_EXEC |=> $stable(len_q))
		else $error("entry count changed outside execute");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised without a finished item");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && !out_free |=> state_q == S_FIN)
		else $error("item left finish while output was blocked");

endmodule

// File: tb/sv/ordered_list_store_core_test.sv
// Self-checking testbench for ordered_list_store_core: list commands against a shadow list.
`timescale 1ns / 1ps

module ordered_list_store_core_test;
	import ols_pkg::*;

	localparam int LIST_CAPACITY = CAPACITY_DEF;
	localparam int DRAIN_CYCLES  = 20;

	typedef struct packed {
		status_t     status;
		logic [9:0]  found;
		logic [10:0] count;
	} list_reply_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic signed [31:0] value;
	logic signed [15:0] position;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic [9:0]         found_index;
	logic [10:0]        entry_count;

	logic [31:0] shadow_list[$];
	list_reply_t command_replies[$];
	int idle_pct;
	int stall_pct;
	int mismatches;
	int sent_items;
	int replies_checked;
	int full_refusals;
	int search_hits;
	int empty_deletes;

	ordered_list_store_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found_index(found_index),
		.entry_count(entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic list_reply_t apply_command(input op_t op, input logic [31:0] word,
			input logic [15:0] pos);
		list_reply_t r;
		int len;
		int p;
		int i;
		len = shadow_list.size();
		p = pos;
		r.status = ST_OK;
		r.found = '0;
		case (op)
		OP_APPEND: begin
			if (len >= LIST_CAPACITY)
				r.status = ST_FULL;
			else
				shadow_list.push_back(word);
		end
		OP_INSERT: begin
			if (pos[15] || p > len)
				r.status = ST_BAD_POS;
			else if (len >= LIST_CAPACITY)
				r.status = ST_FULL;
			else
				shadow_list.insert(p, word);
		end
		OP_SEARCH: begin
			r.status = ST_MISSING;
			for (i = 0; i < len && r.status != ST_OK; i++) begin
				if (shadow_list[i] == word) begin
					r.status = ST_OK;
					r.found = 10'(i);
				end
			end
			if (r.status == ST_OK)
				search_hits++;
		end
		default: begin
			if (len == 0) begin
				r.status = ST_EMPTY;
				empty_deletes++;
			end else if (pos[15] || p >= len) begin
				r.status = ST_BAD_POS;
			end else begin
				shadow_list.delete(p);
			end
		end
		endcase
		if (r.status == ST_FULL)
			full_refusals++;
		r.count = 11'(shadow_list.size());
		return r;
	endfunction

	function automatic logic [31:0] pick_word(input op_t op);
		int r;
		r = $urandom_range(0, 99);
		if (op == OP_SEARCH && shadow_list.size() > 0 && r < 50)
			return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		if (r < 60) begin
			case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return 32'h0000_0001;
			5: return 32'h0000_0055;
			6: return 32'hAAAA_AAAA;
			default: return 32'h5555_5555;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [15:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 16'($urandom_range(0, shadow_list.size() + 1));
		if (r < 88)
			return 16'($urandom_range(16'h8000, 16'hFFFF));
		return 16'($urandom());
	endfunction

	task automatic send_item(input op_t op, input logic [31:0] word, input logic [15:0] pos);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		value <= word;
		position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		command_replies.push_back(apply_command(op, word, pos));
		sent_items++;
	endtask

	task automatic test_empty_list();
		send_item(OP_SEARCH, 32'h0000_0005, 16'h0000);
		send_item(OP_DELETE, 32'h0000_0000, 16'h0000);
		send_item(OP_DELETE, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_INSERT, 32'h0000_0001, 16'h0001);
		send_item(OP_INSERT, 32'h0000_0001, 16'h8000);
		send_item(OP_INSERT, 32'h8000_0000, 16'h0000);
		send_item(OP_DELETE, 32'h0000_0000, 16'h0001);
		send_item(OP_DELETE, 32'h0000_0000, 16'h0000);
	endtask

	task automatic test_fill_to_capacity();
		int k;
		send_item(OP_APPEND, 32'h7FFF_FFFF, 16'h8000);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 16'h7FFF);
		send_item(OP_APPEND, 32'h8000_0000, 16'hFFFF);
		for (k = 3; k < LIST_CAPACITY; k++)
			send_item(OP_APPEND, (k % 4 == 0) ? 32'hFFFF_FFFF : 32'(k), 16'(k));
		send_item(OP_APPEND, 32'h0000_0042, 16'h0000);
		send_item(OP_INSERT, 32'h0000_0042, 16'(LIST_CAPACITY));
		send_item(OP_INSERT, 32'h0000_0042, 16'(LIST_CAPACITY + 1));
		send_item(OP_INSERT, 32'h0000_0042, 16'h7FFF);
	endtask

	task automatic test_search_and_delete();
		send_item(OP_SEARCH, 32'h7FFF_FFFF, 16'hFFFF);
		send_item(OP_SEARCH, 32'hFFFF_FFFF, 16'h0000);
		send_item(OP_SEARCH, 32'h1234_5678, 16'h0000);
		send_item(OP_DELETE, 32'h0000_0000, 16'(LIST_CAPACITY - 1));
		send_item(OP_DELETE, 32'h0000_0000, 16'h7FFF);
		send_item(OP_DELETE, 32'hFFFF_FFFF, 16'h0000);
		send_item(OP_INSERT, 32'h0000_0099, 16'h0007);
		send_item(OP_SEARCH, 32'h0000_0099, 16'h0000);
	endtask

	task automatic test_random_commands(input int items, input int idle_in, input int stall_in,
			input int grow_pct);
		int k;
		int r;
		op_t op;
		idle_pct = idle_in;
		stall_pct = stall_in;
		for (k = 0; k < items; k++) begin
			r = $urandom_range(0, 99);
			if (r < grow_pct)
				op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
			else if (r < grow_pct + 25)
				op = OP_SEARCH;
			else
				op = OP_DELETE;
			send_item(op, pick_word(op), pick_position());
		end
	endtask

	always @(posedge clk) begin : reply_check
		list_reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (command_replies.size() == 0) begin
					$error("reply with none outstanding: status %0d count %0d",
						status, entry_count);
					mismatches++;
				end else begin
					want = command_replies.pop_front();
					replies_checked++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (found_index !== want.found) begin
						$error("found_index: expected %0d, got %0d", want.found, found_index);
						mismatches++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_APPEND;
		value <= '0;
		position <= '0;
		idle_pct = 19;
		stall_pct = 19;
		mismatches = 0;
		sent_items = 0;
		replies_checked = 0;
		full_refusals = 0;
		search_hits = 0;
		empty_deletes = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_capacity();
		test_search_and_delete();
		test_random_commands(140, 19, 19, 45);
		test_random_commands(80, 0, 0, 35);
		test_random_commands(180, 19, 19, 28);
		in_valid <= 1'b0;
		while (command_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("sent %0d commands, checked %0d replies", sent_items, replies_checked);
		$display("full refusals %0d, search hits %0d, deletes on empty list %0d",
			full_refusals, search_hits, empty_deletes);
		if (mismatches == 0)
			$display("ordered_list_store_core_test: done, clean");
		else
			$display("ordered_list_store_core_test: done, errors");
		$finish;
	end

	initial begin
		#200000;
		$display("ordered_list_store_core_test: done, errors");
		$finish;
	end

endmodule

// File: ordered_list_store_core.f
design/ols_pkg.sv
design/ols_cell.sv
design/ordered_list_store_core.sv
tb/sv/ordered_list_store_core_test.sv
